### design/slbs_pkg.sv
// ----------------------------------------------------------------------------
// slbs_pkg: shared types and constants of the status LED and buzzer sequencer
// Operation codes, status bit positions, timing constants and the state
// record that the step logic and the top level both use.
// ----------------------------------------------------------------------------
`default_nettype none

package slbs_pkg;

  // item operation codes (code 3 is unused and changes nothing)
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET_BIT = 2'd1,
    OP_TONE    = 2'd2
  } op_e;

  // tone kinds
  typedef enum logic [1:0] {
    TONE_POWER_ON  = 2'd0,
    TONE_POWER_OFF = 2'd1,
    TONE_MODE      = 2'd2,
    TONE_ALERT     = 2'd3
  } tone_e;

  // status bit positions
  localparam logic [2:0] POWER_ON_BIT       = 3'd0;
  localparam logic [2:0] LOW_BATTERY_BIT    = 3'd1;
  localparam logic [2:0] WATCHDOG_FAULT_BIT = 3'd2;
  localparam logic [2:0] MANUAL_MODE_BIT    = 3'd3;

  // timing constants in ms
  localparam logic [31:0] FAST_BLINK_MS     = 32'd150;
  localparam logic [31:0] SLOW_BLINK_MS     = 32'd500;
  localparam logic [31:0] ALERT_TONE_MS     = 32'd100;
  localparam logic [31:0] CHIRP_PERIOD_RST  = 32'd30000;

  // status flags after reset: only power-on set
  localparam logic [7:0] STATUS_RESET = 8'd1 << POWER_ON_BIT;

  // sequencer state
  typedef struct packed {
    logic [7:0]  status_flags;
    logic [31:0] buzzer_end_time;
    logic        buzzer_active;
    logic [31:0] last_chirp_time;
    logic [31:0] last_toggle_time;
    logic        blink_phase;
    logic        led_level;
    logic        buzzer_level;
  } state_t;

  localparam state_t STATE_RESET = '{
    status_flags:     STATUS_RESET,
    buzzer_end_time:  32'd0,
    buzzer_active:    1'b0,
    last_chirp_time:  32'd0,
    last_toggle_time: 32'd0,
    blink_phase:      1'b0,
    led_level:        1'b0,
    buzzer_level:     1'b0
  };

  // tone length lookup
  function automatic logic [31:0] tone_length(input logic [1:0] kind);
    logic [31:0] len;
    unique case (tone_e'(kind))
      TONE_POWER_ON:  len = 32'd150;
      TONE_POWER_OFF: len = 32'd300;
      TONE_MODE:      len = 32'd40;
      TONE_ALERT:     len = 32'd100;
      default:        len = 32'd100;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### design/status_led_buzzer_sequencer_core.sv
// ----------------------------------------------------------------------------
// status_led_buzzer_sequencer_core: status LED and buzzer sequencer
// Holds the status byte, tone timer, chirp timer and blink timer, and returns
// the LED level, buzzer level and status byte for every item.
// ----------------------------------------------------------------------------
// One item per cycle sustained while the output is not stalled. An accepted
// item sits in the input register, is applied to the state by the step logic,
// and its result is loaded into the result register once the output is free.
// The input register refills while the result register drains, so a stalled
// output only holds back input once both registers are full.
// The chirp period register takes a write in any cycle (always ready) and
// must only be written while no item is in flight.
`default_nettype none

module status_led_buzzer_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [2:0]  bit_index_i,
  input  logic        bit_value_i,
  input  logic [1:0]  tone_kind_i,
  input  logic [31:0] now_ms_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        led_on_o,
  output logic        buzzer_on_o,
  output logic [7:0]  status_byte_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] chirp_period_ms_i
);

  logic             in_valid_q;
  logic [1:0]       op_q;
  logic [2:0]       bit_index_q;
  logic             bit_value_q;
  logic [1:0]       tone_kind_q;
  logic [31:0]      now_q;
  logic             out_valid_q;
  logic             led_q;
  logic             buzzer_q;
  logic [7:0]       status_q;
  logic [31:0]      chirp_period_q;
  slbs_pkg::state_t state_q;
  slbs_pkg::state_t state_d;
  logic             advance;

  // handshake
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chirp_period_q <= slbs_pkg::CHIRP_PERIOD_RST;
    end else if (cfg_valid_i) begin
      chirp_period_q <= chirp_period_ms_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q        <= operation_i;
      bit_index_q <= bit_index_i;
      bit_value_q <= bit_value_i;
      tone_kind_q <= tone_kind_i;
      now_q       <= now_ms_i;
    end
  end

  // next state for the item in the input register
  slbs_step u_step (
    .state_i           (state_q),
    .operation_i       (op_q),
    .bit_index_i       (bit_index_q),
    .bit_value_i       (bit_value_q),
    .tone_kind_i       (tone_kind_q),
    .now_ms_i          (now_q),
    .chirp_period_ms_i (chirp_period_q),
    .state_o           (state_d)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slbs_pkg::STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      led_q    <= state_d.led_level;
      buzzer_q <= state_d.buzzer_level;
      status_q <= state_d.status_flags;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign led_on_o      = led_q;
  assign buzzer_on_o   = buzzer_q;
  assign status_byte_o = status_q;

endmodule

`default_nettype wire

### design/slbs_step.sv
// ----------------------------------------------------------------------------
// slbs_step: next-state logic for one item
// Applies a tick, a status-bit write or a tone start to the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module slbs_step (
  input  slbs_pkg::state_t state_i,
  input  logic [1:0]       operation_i,
  input  logic [2:0]       bit_index_i,
  input  logic             bit_value_i,
  input  logic [1:0]       tone_kind_i,
  input  logic [31:0]      now_ms_i,
  input  logic [31:0]      chirp_period_ms_i,
  output slbs_pkg::state_t state_o
);

  slbs_pkg::state_t s;
  logic [31:0]      chirp_elapsed;
  logic [31:0]      toggle_elapsed;
  logic [31:0]      blink_period;
  logic             power_on;
  logic             low_batt;
  logic             fast_blink;
  logic             slow_blink;

  // wrap-safe elapsed times and blink mode from the current flags
  always_comb begin
    chirp_elapsed  = now_ms_i - state_i.last_chirp_time;
    toggle_elapsed = now_ms_i - state_i.last_toggle_time;
    power_on   = state_i.status_flags[slbs_pkg::POWER_ON_BIT];
    low_batt   = state_i.status_flags[slbs_pkg::LOW_BATTERY_BIT];
    fast_blink = state_i.status_flags[slbs_pkg::WATCHDOG_FAULT_BIT] || low_batt;
    slow_blink = state_i.status_flags[slbs_pkg::MANUAL_MODE_BIT];
    blink_period = fast_blink ? slbs_pkg::FAST_BLINK_MS : slbs_pkg::SLOW_BLINK_MS;
  end

  // apply the item
  always_comb begin
    s = state_i;
    unique case (slbs_pkg::op_e'(operation_i))
      slbs_pkg::OP_TICK: begin
        // end of tone, plain unsigned compare
        if (state_i.buzzer_active && (now_ms_i >= state_i.buzzer_end_time)) begin
          s.buzzer_level  = 1'b0;
          s.buzzer_active = 1'b0;
        end
        // low battery chirp
        if (low_batt && power_on && (chirp_elapsed >= chirp_period_ms_i)) begin
          s.last_chirp_time = now_ms_i;
          s.buzzer_level    = 1'b1;
          s.buzzer_end_time = now_ms_i + slbs_pkg::ALERT_TONE_MS;
          s.buzzer_active   = 1'b1;
        end
        // led drive
        if (!power_on) begin
          s.led_level = 1'b0;
        end else if (fast_blink || slow_blink) begin
          if (toggle_elapsed >= blink_period) begin
            s.last_toggle_time = now_ms_i;
            s.blink_phase      = !state_i.blink_phase;
            s.led_level        = !state_i.blink_phase;
          end
        end else begin
          s.led_level = 1'b1;
        end
      end
      slbs_pkg::OP_SET_BIT: begin
        s.status_flags[bit_index_i] = bit_value_i;
      end
      slbs_pkg::OP_TONE: begin
        s.buzzer_level    = 1'b1;
        s.buzzer_end_time = now_ms_i + slbs_pkg::tone_length(tone_kind_i);
        s.buzzer_active   = 1'b1;
      end
      default: begin
        s = state_i;
      end
    endcase
    state_o = s;
  end

endmodule

`default_nettype wire

### design/slbs_checker.sv
// ----------------------------------------------------------------------------
// slbs_checker: port-level checks for the sequencer
// Watches the top-level ports for result latency and item effects.
// ----------------------------------------------------------------------------
`default_nettype none

module slbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  operation_i,
  input logic [2:0]  bit_index_i,
  input logic        bit_value_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        led_on_o,
  input logic        buzzer_on_o,
  input logic [7:0]  status_byte_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(led_on_o) && $stable(buzzer_on_o) && $stable(status_byte_o)))
    else $error("stalled result changed");

  // a result only rises after an input transfer has passed the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without input transfer");

  // transfer followed by a free output yields a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 (!out_valid_o || out_ready_i) |=> out_valid_o)
    else $error("result latency exceeded");

  // tone item reaching a free output reports the buzzer on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (operation_i == slbs_pkg::OP_TONE))
      ##1 (!out_valid_o || out_ready_i)
      |=> (out_valid_o && buzzer_on_o))
    else $error("tone item did not raise buzzer");

  // set-bit item reaching a free output shows the written bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (operation_i == slbs_pkg::OP_SET_BIT))
      ##1 (!out_valid_o || out_ready_i)
      |=> (status_byte_o[$past(bit_index_i, 2)] == $past(bit_value_i, 2)))
    else $error("status bit write not reflected");

endmodule

bind status_led_buzzer_sequencer_core slbs_checker u_slbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .operation_i   (operation_i),
  .bit_index_i   (bit_index_i),
  .bit_value_i   (bit_value_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .led_on_o      (led_on_o),
  .buzzer_on_o   (buzzer_on_o),
  .status_byte_o (status_byte_o)
);

`default_nettype wire
